>>> src/lbv_pkg.sv
// Package for the Lagrange basis value/slope block.
// Shared widths and fixed-point constants; no dependencies.
package lbv_pkg;

    localparam int LBV_MAX_ORDER_DEF = 8;   // default order limit
    localparam int LBV_ORDER_W       = 4;   // poly_order register width
    localparam int LBV_X_W           = 16;  // point_x width (Q2.14)
    localparam int LBV_X_FRAC        = 14;  // fraction bits of point_x
    localparam int LBV_IDX_W         = 4;   // basis_index width
    localparam int LBV_OUT_W         = 32;  // Q16.16 result width
    localparam int LBV_ONE_FRAC      = 24;  // running products are Q.24
    localparam int LBV_PCAP_BITS     = 42;  // product magnitude cap is 2^42
    localparam int LBV_RND_SHIFT     = 8;   // Q.24 -> Q16.16
    localparam int LBV_DIV_BITS      = 8;   // quotient bits per divider cycle

endpackage

>>> src/lbv_point_if.sv
// Input channel of the Lagrange basis block: one evaluation point per word.
// Depends on lbv_pkg.
interface lbv_point_if import lbv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [LBV_X_W-1:0] point_x;

    modport source (output valid, point_x, input ready);
    modport sink   (input valid, point_x, output ready);
endinterface

>>> src/lbv_basis_if.sv
// Output channel of the Lagrange basis block: one basis result per word.
// Depends on lbv_pkg.
interface lbv_basis_if import lbv_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic        [LBV_IDX_W-1:0] basis_index;
    logic signed [LBV_OUT_W-1:0] basis_value;
    logic signed [LBV_OUT_W-1:0] basis_slope;
    logic                        last_of_run;

    modport source (output valid, basis_index, basis_value, basis_slope, last_of_run,
                    input ready);
    modport sink   (input valid, basis_index, basis_value, basis_slope, last_of_run,
                    output ready);
endinterface

>>> src/lagrange_basis_value_and_slope_top.sv
// Lagrange basis value and slope on equispaced nodes, one shared multiply/divide unit.
// Each product step runs pick, 2 multiply halves, divider load, divider steps of 8 bits
// each and writeback; a point of order n also passes accept, setup, skips and emit, and
// waits in emit while the output word is held. One point at a time; i_point.ready is
// high only while idle. Synchronous active-low reset: order register to 1, sequencer
// idle, output word empty.
module lagrange_basis_value_and_slope_top import lbv_pkg::*; #(
    parameter int MAX_ORDER = LBV_MAX_ORDER_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [LBV_ORDER_W-1:0] i_cfg_wdata,
    lbv_point_if.sink              i_point,
    lbv_basis_if.source            o_basis
);

    localparam int CNT_W     = $clog2(MAX_ORDER + 2);
    localparam int D_W       = $clog2(MAX_ORDER + 1);
    localparam int REM_W     = D_W + 1;
    localparam int AW        = $clog2(MAX_ORDER * 3 * (2 ** LBV_X_FRAC) + 1);
    localparam int A_W       = AW + 1;
    localparam int P_W       = LBV_PCAP_BITS + 1;
    localparam int LO_W      = (P_W + 1) / 2;
    localparam int ACC_W     = P_W + AW;
    localparam int DIV_W     = ((ACC_W - 1 + LBV_DIV_BITS - 1) / LBV_DIV_BITS) * LBV_DIV_BITS;
    localparam int DIV_STEPS = DIV_W / LBV_DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
    localparam int SL_W      = P_W + $clog2(MAX_ORDER + 1);

    localparam logic [P_W-1:0]   P_ONE   = P_W'(1) << LBV_ONE_FRAC;
    localparam logic [P_W-1:0]   P_CAP   = P_W'(1) << LBV_PCAP_BITS;
    localparam logic [DIV_W-1:0] DVD_CAP = DIV_W'(1) << LBV_PCAP_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_PICK, S_MUL_LO, S_MUL_HI, S_DIV_LOAD, S_DIV, S_POST, S_EMIT
    } t_state;

    // Q.24 magnitude with sign to Q16.16, round half away, saturate
    function automatic logic [LBV_OUT_W-1:0] to_q16(input logic neg,
                                                   input logic [SL_W-1:0] mag);
        logic [SL_W-1:0] m;
        logic [SL_W-1:0] neg_lim;
        logic [SL_W-1:0] pos_lim;
        begin
            neg_lim = SL_W'(1) << (LBV_OUT_W - 1);
            pos_lim = neg_lim - SL_W'(1);
            m = (mag + (SL_W'(1) << (LBV_RND_SHIFT - 1))) >> LBV_RND_SHIFT;
            if (neg) begin
                if (m > neg_lim) m = neg_lim;
                to_q16 = LBV_OUT_W'(0) - m[LBV_OUT_W-1:0];
            end else begin
                if (m > pos_lim) m = pos_lim;
                to_q16 = m[LBV_OUT_W-1:0];
            end
        end
    endfunction

    t_state                    r_state;
    logic [LBV_ORDER_W-1:0]    r_order;
    logic signed [LBV_X_W-1:0] r_x;
    logic [CNT_W-1:0]          r_n;
    logic signed [A_W-1:0]     r_nx;
    logic [CNT_W-1:0]          r_i;
    logic [CNT_W-1:0]          r_j;
    logic [CNT_W-1:0]          r_k;
    logic                      r_slope_ph;
    logic                      r_p_neg;
    logic [P_W-1:0]            r_p_mag;
    logic                      r_phi_neg;
    logic [P_W-1:0]            r_phi_mag;
    logic [SL_W-1:0]           r_slope;
    // shared unit operands
    logic [AW-1:0]             r_nmag;
    logic [D_W-1:0]            r_d;
    logic                      r_neg;
    logic                      r_shift_hi;
    logic                      r_scale;
    logic [ACC_W-1:0]          r_acc;
    logic [DIV_W-1:0]          r_dvd;
    logic [REM_W-1:0]          r_rem;
    logic [DCNT_W-1:0]         r_dcnt;
    // output word
    logic                      r_out_valid;
    logic [LBV_IDX_W-1:0]      r_out_index;
    logic [LBV_OUT_W-1:0]      r_out_value;
    logic [LBV_OUT_W-1:0]      r_out_slope;
    logic                      r_out_last;

    logic [CNT_W-1:0]          n_ord;
    logic signed [A_W-1:0]     a_off;
    logic signed [A_W-1:0]     a_sum;
    logic                      a_neg;
    logic [AW-1:0]             a_mag;
    logic [D_W-1:0]            dj_mag;
    logic [D_W-1:0]            dk_mag;
    logic [ACC_W-1:0]          lo_ext;
    logic [ACC_W-1:0]          hi_ext;
    logic [ACC_W-1:0]          num_ext;
    logic [ACC_W-1:0]          mul_half;
    logic [ACC_W-1:0]          mul_prod;
    logic [ACC_W-1:0]          bias;
    logic [DIV_W-1:0]          dvd_load;
    logic [REM_W-1:0]          div_rem;
    logic [DIV_W-1:0]          div_q;
    logic [P_W-1:0]            q_mag;
    logic                      q_neg;
    logic [SL_W-1:0]           q_ext;
    logic [SL_W-1:0]           q_signed;
    logic [SL_W-1:0]           slope_mag;

    always_comb begin
        if (r_order == '0) begin
            n_ord = CNT_W'(1);
        end else if (r_order > MAX_ORDER) begin
            n_ord = CNT_W'(MAX_ORDER);
        end else begin
            n_ord = CNT_W'(r_order);
        end
    end

    // numerator a_j = n*x + 16384*(n - 2j)
    assign a_off  = (A_W'(r_n) - A_W'({r_j, 1'b0})) << LBV_X_FRAC;
    assign a_sum  = r_nx + a_off;
    assign a_neg  = a_sum[A_W-1];
    assign a_mag  = AW'(a_neg ? -a_sum : a_sum);
    assign dj_mag = D_W'((r_j > r_i) ? (r_j - r_i) : (r_i - r_j));
    assign dk_mag = D_W'((r_k > r_i) ? (r_k - r_i) : (r_i - r_k));

    // 43-bit magnitude split in two halves through one multiplier
    assign lo_ext   = ACC_W'(r_p_mag[LO_W-1:0]);
    assign hi_ext   = ACC_W'(r_p_mag[P_W-1:LO_W]);
    assign num_ext  = ACC_W'(r_nmag);
    assign mul_half = (r_state == S_MUL_HI) ? hi_ext : lo_ext;
    assign mul_prod = mul_half * num_ext;
    // half the divisor, added before the floor division
    assign bias    = r_shift_hi ? (ACC_W'(r_d) << LBV_X_FRAC) : ACC_W'(r_d);
    assign dvd_load = r_shift_hi ? DIV_W'(r_acc >> (LBV_X_FRAC + 1)) : DIV_W'(r_acc >> 1);

    // restoring division by the small divisor, several quotient bits per cycle
    always_comb begin
        div_rem = r_rem;
        div_q   = r_dvd;
        for (int b = 0; b < LBV_DIV_BITS; b++) begin
            div_rem = {div_rem[REM_W-2:0], div_q[DIV_W-1]};
            div_q   = {div_q[DIV_W-2:0], 1'b0};
            if (div_rem >= REM_W'(r_d)) begin
                div_rem  = div_rem - REM_W'(r_d);
                div_q[0] = 1'b1;
            end
        end
    end

    assign q_mag     = (r_dvd > DVD_CAP) ? P_CAP : r_dvd[P_W-1:0];
    assign q_neg     = r_neg & (q_mag != '0);
    assign q_ext     = SL_W'(q_mag);
    assign q_signed  = q_neg ? (~q_ext + SL_W'(1)) : q_ext;
    assign slope_mag = r_slope[SL_W-1] ? (~r_slope + SL_W'(1)) : r_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_order     <= LBV_ORDER_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            if (r_state == S_EMIT && (!r_out_valid || o_basis.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_basis.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_point.valid) begin
                        r_x     <= i_point.point_x;
                        r_n     <= n_ord;
                        r_state <= S_SETUP;
                    end
                end

                S_SETUP: begin
                    r_nx       <= A_W'($signed({1'b0, r_n})) * A_W'(r_x);
                    r_i        <= '0;
                    r_j        <= '0;
                    r_slope_ph <= 1'b0;
                    r_p_neg    <= 1'b0;
                    r_p_mag    <= P_ONE;
                    r_slope    <= '0;
                    r_state    <= S_PICK;
                end

                S_PICK: begin
                    if (!r_slope_ph) begin
                        if (r_j > r_n) begin
                            r_phi_neg  <= r_p_neg;
                            r_phi_mag  <= r_p_mag;
                            r_slope_ph <= 1'b1;
                            r_k        <= '0;
                            r_j        <= '0;
                            r_p_neg    <= 1'b0;
                            r_p_mag    <= P_ONE;
                        end else if (r_j == r_i) begin
                            r_j <= r_j + CNT_W'(1);
                        end else begin
                            r_nmag     <= a_mag;
                            r_d        <= dj_mag;
                            r_neg      <= r_p_neg ^ a_neg ^ (r_j > r_i);
                            r_shift_hi <= 1'b1;
                            r_scale    <= 1'b0;
                            r_state    <= S_MUL_LO;
                        end
                    end else begin
                        if (r_k > r_n) begin
                            r_state <= S_EMIT;
                        end else if (r_k == r_i) begin
                            r_k <= r_k + CNT_W'(1);
                        end else if (r_j > r_n) begin
                            // slope term: scale by n / (2*(i-k))
                            r_nmag     <= AW'(r_n);
                            r_d        <= dk_mag;
                            r_neg      <= r_p_neg ^ (r_k > r_i);
                            r_shift_hi <= 1'b0;
                            r_scale    <= 1'b1;
                            r_state    <= S_MUL_LO;
                        end else if (r_j == r_i || r_j == r_k) begin
                            r_j <= r_j + CNT_W'(1);
                        end else begin
                            r_nmag     <= a_mag;
                            r_d        <= dj_mag;
                            r_neg      <= r_p_neg ^ a_neg ^ (r_j > r_i);
                            r_shift_hi <= 1'b1;
                            r_scale    <= 1'b0;
                            r_state    <= S_MUL_LO;
                        end
                    end
                end

                S_MUL_LO: begin
                    r_acc   <= mul_prod + bias;
                    r_state <= S_MUL_HI;
                end

                S_MUL_HI: begin
                    r_acc   <= r_acc + (mul_prod << LO_W);
                    r_state <= S_DIV_LOAD;
                end

                S_DIV_LOAD: begin
                    r_dvd   <= dvd_load;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_dvd  <= div_q;
                    r_rem  <= div_rem;
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_POST;
                    end
                end

                S_POST: begin
                    if (r_scale) begin
                        r_slope <= r_slope + q_signed;
                        r_p_neg <= 1'b0;
                        r_p_mag <= P_ONE;
                        r_j     <= '0;
                        r_k     <= r_k + CNT_W'(1);
                    end else begin
                        r_p_neg <= q_neg;
                        r_p_mag <= q_mag;
                        r_j     <= r_j + CNT_W'(1);
                    end
                    r_state <= S_PICK;
                end

                S_EMIT: begin
                    if (!r_out_valid || o_basis.ready) begin
                        r_out_index <= LBV_IDX_W'(r_i);
                        r_out_value <= to_q16(r_phi_neg, SL_W'(r_phi_mag));
                        r_out_slope <= to_q16(r_slope[SL_W-1], slope_mag);
                        r_out_last  <= (r_i == r_n);
                        if (r_i == r_n) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i        <= r_i + CNT_W'(1);
                            r_j        <= '0;
                            r_slope_ph <= 1'b0;
                            r_p_neg    <= 1'b0;
                            r_p_mag    <= P_ONE;
                            r_slope    <= '0;
                            r_state    <= S_PICK;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_point.ready       = (r_state == S_IDLE);
    assign o_basis.valid       = r_out_valid;
    assign o_basis.basis_index = r_out_index;
    assign o_basis.basis_value = r_out_value;
    assign o_basis.basis_slope = r_out_slope;
    assign o_basis.last_of_run = r_out_last;

endmodule
